// File: rtl/npws_pkg.sv
package npws_pkg;

	// store and field geometry
	localparam int MAX_POINTS = 1024;
	localparam int IDX_W      = 10;
	localparam int CNT_W      = 11;
	localparam int COORD_W    = 16;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int SQ_W       = 2 * COORD_W;
	localparam int DIST_W     = SQ_W + 1;
	localparam int TOL_W      = 33;
	localparam int PT_W       = 2 * COORD_W;

	// stream payload widths
	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 48;

	// command codes on s_tuser
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// configuration register indexes
	localparam logic CFG_POINT_COUNT = 1'b0;
	localparam logic CFG_TOLERANCE   = 1'b1;

	// candidate kinds in the distance pipeline
	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_LEFT  = 2'd1,
		KIND_RIGHT = 2'd2
	} cand_kind_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic start;
		logic issue;
		logic emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic issue_done;
		logic stopped;
		logic pipe_empty;
		logic out_free;
	} dp_sts_t;

endpackage

// File: rtl/nearest_point_window_search_core.sv
// load item: accepted while idle and written to the point store, no result
// query item: one store read per cycle (start slot, then left and right per ring);
// one item in flight at a time
// arst_n clears control, point_count to 1 and tolerance_square to 0; the store is kept
module nearest_point_window_search_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// slot_index, coord_x, coord_y, start_index, zero pad
	input  logic [npws_pkg::S_DATA_W-1:0]      s_tdata,
	// command
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// nearest_index, best_square_distance, zero pad
	output logic [npws_pkg::M_DATA_W-1:0]      m_tdata,
	// within_tolerance
	output logic                               m_tuser,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_index,
	input  logic [npws_pkg::TOL_W-1:0]         cfg_data
);

	localparam int IW = npws_pkg::IDX_W;
	localparam int CW = npws_pkg::COORD_W;

	npws_pkg::dp_cmd_t cmd;
	npws_pkg::dp_sts_t sts;
	logic                        in_ready;
	logic [IW-1:0]               slot_index;
	logic signed [CW-1:0]        coord_x;
	logic signed [CW-1:0]        coord_y;
	logic [IW-1:0]               start_index;
	logic [IW-1:0]               nearest_index;
	logic [npws_pkg::DIST_W-1:0] best_square_distance;

	// input field unpacking
	assign slot_index  = s_tdata[IW-1:0];
	assign coord_x     = s_tdata[IW+CW-1:IW];
	assign coord_y     = s_tdata[IW+2*CW-1:IW+CW];
	assign start_index = s_tdata[2*IW+2*CW-1:IW+2*CW];

	assign s_tready  = in_ready;
	assign cfg_ready = 1'b1;

	npws_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_command (s_tuser),
		.in_ready   (in_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	npws_datapath u_datapath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.sts                  (sts),
		.cfg_write            (cfg_valid),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.slot_index           (slot_index),
		.coord_x              (coord_x),
		.coord_y              (coord_y),
		.start_index          (start_index),
		.out_ready            (m_tready),
		.out_valid            (m_tvalid),
		.nearest_index        (nearest_index),
		.best_square_distance (best_square_distance),
		.within_tolerance     (m_tuser)
	);

	// result packing
	assign m_tdata = {
		{(npws_pkg::M_DATA_W - IW - npws_pkg::DIST_W){1'b0}},
		best_square_distance,
		nearest_index
	};

endmodule

// File: rtl/npws_ctrl.sv
module npws_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_command,
	output logic               in_ready,
	input  npws_pkg::dp_sts_t  sts,
	output npws_pkg::dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	// next state and datapath commands
	always_comb begin
		state_d   = state_q;
		cmd.load  = 1'b0;
		cmd.start = 1'b0;
		cmd.issue = 1'b0;
		cmd.emit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_command == npws_pkg::CMD_QUERY) begin
						cmd.start = 1'b1;
						state_d   = ST_RUN;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_RUN: begin
				if (sts.issue_done || sts.stopped) begin
					state_d = ST_DRAIN;
				end else begin
					cmd.issue = 1'b1;
				end
			end
			ST_DRAIN: begin
				if (sts.pipe_empty && sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/npws_datapath.sv
module npws_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  npws_pkg::dp_cmd_t                      cmd,
	output npws_pkg::dp_sts_t                      sts,
	input  logic                                   cfg_write,
	input  logic                                   cfg_index,
	input  logic [npws_pkg::TOL_W-1:0]             cfg_data,
	input  logic [npws_pkg::IDX_W-1:0]             slot_index,
	input  logic signed [npws_pkg::COORD_W-1:0]    coord_x,
	input  logic signed [npws_pkg::COORD_W-1:0]    coord_y,
	input  logic [npws_pkg::IDX_W-1:0]             start_index,
	input  logic                                   out_ready,
	output logic                                   out_valid,
	output logic [npws_pkg::IDX_W-1:0]             nearest_index,
	output logic [npws_pkg::DIST_W-1:0]            best_square_distance,
	output logic                                   within_tolerance
);

	localparam int IW = npws_pkg::IDX_W;
	localparam int CW = npws_pkg::COORD_W;
	localparam int DIFF_W_L = npws_pkg::DIFF_W;
	localparam int PROD_W_L = npws_pkg::PROD_W;

	// configuration
	logic [npws_pkg::CNT_W-1:0] point_count_q;
	logic [npws_pkg::TOL_W-1:0] tol_q;

	// query context and window
	logic signed [CW-1:0] sx_q;
	logic signed [CW-1:0] sy_q;
	logic [IW-1:0]        last_q;
	logic [IW-1:0]        left_q;
	logic [IW-1:0]        right_q;
	logic                 phase_left_q;

	// point store
	logic [npws_pkg::PT_W-1:0] mem_q [npws_pkg::MAX_POINTS];

	// pipeline
	logic                      v_s1;
	npws_pkg::cand_kind_t      kind_s1;
	logic [IW-1:0]             idx_s1;
	logic [npws_pkg::PT_W-1:0] pt_s1;
	logic                      v_s2;
	npws_pkg::cand_kind_t      kind_s2;
	logic [IW-1:0]             idx_s2;
	logic [npws_pkg::SQ_W-1:0] sqx_s2;
	logic [npws_pkg::SQ_W-1:0] sqy_s2;

	// running best
	logic [npws_pkg::DIST_W-1:0] best_q;
	logic [IW-1:0]               best_idx_q;
	logic                        live_q;

	// output register
	logic                        out_valid_q;
	logic [IW-1:0]               out_idx_q;
	logic [npws_pkg::DIST_W-1:0] out_dist_q;
	logic                        out_within_q;

	logic [IW-1:0]               last_new;
	logic [npws_pkg::CNT_W-1:0]  cnt_m1;
	logic [IW-1:0]               start_clamped;
	logic [IW-1:0]               left_dec;
	logic [IW-1:0]               right_inc;
	logic [IW-1:0]               rd_addr;
	logic                        rd_en;
	npws_pkg::cand_kind_t        rd_kind;
	logic signed [CW-1:0]        px_s1;
	logic signed [CW-1:0]        py_s1;
	logic signed [DIFF_W_L-1:0]  dx;
	logic signed [DIFF_W_L-1:0]  dy;
	logic signed [PROD_W_L-1:0]  px2;
	logic signed [PROD_W_L-1:0]  py2;
	logic [npws_pkg::DIST_W-1:0] d_sum;
	logic                        best_below;

	// effective last slot and clamped start
	always_comb begin
		cnt_m1 = point_count_q - 1'b1;
		if (point_count_q == '0) begin
			last_new = '0;
		end else if (point_count_q > npws_pkg::CNT_W'(npws_pkg::MAX_POINTS)) begin
			last_new = IW'(npws_pkg::MAX_POINTS - 1);
		end else begin
			last_new = cnt_m1[IW-1:0];
		end
		start_clamped = (start_index > last_new) ? last_new : start_index;
	end

	// next candidate address
	always_comb begin
		left_dec  = (left_q != '0) ? left_q - 1'b1 : left_q;
		right_inc = (right_q != last_q) ? right_q + 1'b1 : right_q;
		rd_en     = cmd.start | cmd.issue;
		if (cmd.start) begin
			rd_addr = start_clamped;
			rd_kind = npws_pkg::KIND_START;
		end else if (phase_left_q) begin
			rd_addr = left_dec;
			rd_kind = npws_pkg::KIND_LEFT;
		end else begin
			rd_addr = right_inc;
			rd_kind = npws_pkg::KIND_RIGHT;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= npws_pkg::CNT_W'(1);
			tol_q         <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				npws_pkg::CFG_POINT_COUNT: point_count_q <= cfg_data[npws_pkg::CNT_W-1:0];
				npws_pkg::CFG_TOLERANCE:   tol_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	// query context and window bounds
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sx_q    <= coord_x;
			sy_q    <= coord_y;
			last_q  <= last_new;
			left_q  <= start_clamped;
			right_q <= start_clamped;
		end else if (cmd.issue) begin
			if (phase_left_q) begin
				left_q <= left_dec;
			end else begin
				right_q <= right_inc;
			end
		end
	end

	// ring phase: left first, then right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_left_q <= 1'b1;
		end else if (cmd.start) begin
			phase_left_q <= 1'b1;
		end else if (cmd.issue) begin
			phase_left_q <= ~phase_left_q;
		end
	end

	// point store: write on load, registered read
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem_q[slot_index] <= {coord_y, coord_x};
		end
		if (rd_en) begin
			pt_s1 <= mem_q[rd_addr];
		end
	end

	// squared differences
	always_comb begin
		px_s1 = pt_s1[CW-1:0];
		py_s1 = pt_s1[2*CW-1:CW];
		dx    = DIFF_W_L'(px_s1) - DIFF_W_L'(sx_q);
		dy    = DIFF_W_L'(py_s1) - DIFF_W_L'(sy_q);
		px2   = dx * dx;
		py2   = dy * dy;
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (rd_en) begin
			kind_s1 <= rd_kind;
			idx_s1  <= rd_addr;
		end
		kind_s2 <= kind_s1;
		idx_s2  <= idx_s1;
		sqx_s2  <= px2[npws_pkg::SQ_W-1:0];
		sqy_s2  <= py2[npws_pkg::SQ_W-1:0];
	end

	// compare stage
	assign d_sum      = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign best_below = (best_q < tol_q);

	// search stays live until a ring opens with best below tolerance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else if (cmd.start) begin
			live_q <= 1'b1;
		end else if (v_s2 && kind_s2 == npws_pkg::KIND_LEFT && live_q && best_below) begin
			live_q <= 1'b0;
		end
	end

	// best candidate update
	always_ff @(posedge clk) begin
		if (v_s2) begin
			case (kind_s2)
				npws_pkg::KIND_START: begin
					best_q     <= d_sum;
					best_idx_q <= idx_s2;
				end
				npws_pkg::KIND_LEFT: begin
					if (live_q && !best_below && d_sum < best_q) begin
						best_q     <= d_sum;
						best_idx_q <= idx_s2;
					end
				end
				npws_pkg::KIND_RIGHT: begin
					if (live_q && d_sum < best_q) begin
						best_q     <= d_sum;
						best_idx_q <= idx_s2;
					end
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_idx_q    <= best_idx_q;
			out_dist_q   <= best_q;
			out_within_q <= best_below;
		end
	end

	// status to controller
	always_comb begin
		sts.issue_done = phase_left_q && (left_q == '0) && (right_q == last_q);
		sts.stopped    = ~live_q;
		sts.pipe_empty = ~v_s1 & ~v_s2;
		sts.out_free   = ~out_valid_q | out_ready;
	end

	assign out_valid            = out_valid_q;
	assign nearest_index        = out_idx_q;
	assign best_square_distance = out_dist_q;
	assign within_tolerance     = out_within_q;

endmodule

// File: sim/npws_result_checker.sv
module npws_result_checker
	import npws_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	// slot_index, coord_x, coord_y, start_index, zero pad
	input  logic [S_DATA_W-1:0] s_tdata,
	// command
	input  logic                s_tuser,
	input  logic                m_tvalid,
	input  logic                m_tready,
	// nearest_index, best_square_distance, zero pad
	input  logic [M_DATA_W-1:0] m_tdata,
	// within_tolerance
	input  logic                m_tuser,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [TOL_W-1:0]    cfg_data,
	output int                  outstanding,
	output int                  mismatches
);

	localparam int PRINT_CAP = 100;

	typedef struct packed {
		logic [IDX_W-1:0]  index;
		logic [DIST_W-1:0] sq_dist;
		logic              hit;
	} nearest_t;

	// shadow copy of the point store and the two registers
	logic signed [COORD_W-1:0] store_x [MAX_POINTS];
	logic signed [COORD_W-1:0] store_y [MAX_POINTS];
	logic [CNT_W-1:0]          point_count = 1;
	logic [TOL_W-1:0]          tolerance_square = '0;
	nearest_t                  nearest_due_q [$];
	int                        results_seen = 0;

	initial begin
		outstanding = 0;
		mismatches  = 0;
		foreach (store_x[i]) begin
			store_x[i] = '0;
			store_y[i] = '0;
		end
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_CAP) begin
			$display("mismatch: %s", what);
		end
	endtask

	// exact squared distance from a stored point to the search point
	function automatic logic [DIST_W-1:0] square_dist(input int slot,
			input logic signed [COORD_W-1:0] qx, input logic signed [COORD_W-1:0] qy);
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic signed [PROD_W-1:0] sx;
		logic signed [PROD_W-1:0] sy;
		dx = store_x[slot] - qx;
		dy = store_y[slot] - qy;
		sx = dx * dx;
		sy = dy * dy;
		return sx[SQ_W-1:0] + sy[SQ_W-1:0];
	endfunction

	// window search growing one slot left and right per ring
	function automatic nearest_t find_nearest(input logic signed [COORD_W-1:0] qx,
			input logic signed [COORD_W-1:0] qy, input logic [IDX_W-1:0] start_raw);
		nearest_t          r;
		int                n;
		int                left;
		int                right;
		int                first;
		logic [DIST_W-1:0] cand;
		if (point_count == 0) begin
			n = 1;
		end else if (point_count > MAX_POINTS) begin
			n = MAX_POINTS;
		end else begin
			n = int'(point_count);
		end
		first = (int'(start_raw) > n - 1) ? n - 1 : int'(start_raw);
		left = first;
		right = first;
		r.index = IDX_W'(first);
		r.sq_dist = square_dist(first, qx, qy);
		while (!(r.sq_dist < tolerance_square) && !(left == 0 && right == n - 1)) begin
			if (left > 0) begin
				left--;
			end
			if (right < n - 1) begin
				right++;
			end
			// left end first, only a strictly closer point wins
			cand = square_dist(left, qx, qy);
			if (cand < r.sq_dist) begin
				r.sq_dist = cand;
				r.index = IDX_W'(left);
			end
			cand = square_dist(right, qx, qy);
			if (cand < r.sq_dist) begin
				r.sq_dist = cand;
				r.index = IDX_W'(right);
			end
		end
		r.hit = (r.sq_dist < tolerance_square);
		return r;
	endfunction

	// watch config, results and input items at each rising edge
	always @(posedge clk) begin : monitor
		nearest_t                  want;
		logic [IDX_W-1:0]          got_index;
		logic [DIST_W-1:0]         got_dist;
		logic [IDX_W-1:0]          slot;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		if (!arst_n) begin
			point_count = 1;
			tolerance_square = '0;
			nearest_due_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_POINT_COUNT) begin
					point_count = cfg_data[CNT_W-1:0];
				end else if (cfg_index == CFG_TOLERANCE) begin
					tolerance_square = cfg_data;
				end
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				got_index = m_tdata[IDX_W-1:0];
				got_dist = m_tdata[IDX_W +: DIST_W];
				if (nearest_due_q.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with no query waiting",
						results_seen));
				end else begin
					want = nearest_due_q.pop_front();
					if (got_index !== want.index) begin
						report_mismatch($sformatf("result %0d nearest_index %0d, expected %0d",
							results_seen, got_index, want.index));
					end
					if (got_dist !== want.sq_dist) begin
						report_mismatch($sformatf(
							"result %0d best_square_distance %0d, expected %0d",
							results_seen, got_dist, want.sq_dist));
					end
					if (m_tuser !== want.hit) begin
						report_mismatch($sformatf("result %0d within_tolerance %0b, expected %0b",
							results_seen, m_tuser, want.hit));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				slot = s_tdata[IDX_W-1:0];
				x = s_tdata[IDX_W +: COORD_W];
				y = s_tdata[IDX_W + COORD_W +: COORD_W];
				if (s_tuser == CMD_LOAD) begin
					store_x[slot] = x;
					store_y[slot] = y;
				end else begin
					nearest_due_q.push_back(find_nearest(x, y,
						s_tdata[IDX_W + 2 * COORD_W +: IDX_W]));
				end
			end
		end
		outstanding = nearest_due_q.size();
	end

endmodule

// File: sim/tb_nearest_point_window_search_core.sv
module tb_nearest_point_window_search_core;
	import npws_pkg::*;

	localparam int ITEMS          = 1160;
	localparam int TAIL_ITEMS     = 150;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 16;
	localparam int DRAIN_CYCLES   = 2 * MAX_POINTS + 16;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int FULL_SPREAD    = -1;
	localparam int COORD_MAX      = 2 ** (COORD_W - 1) - 1;
	localparam int COORD_MIN      = -(2 ** (COORD_W - 1));
	localparam int COUNT_ALL_ONES = 2 ** CNT_W - 1;

	localparam logic [COORD_W-1:0] C_HI = COORD_W'(COORD_MAX);
	localparam logic [COORD_W-1:0] C_LO = COORD_W'(COORD_MIN);
	// just above the largest distance two points can have
	localparam logic [TOL_W-1:0] TOL_ABOVE_ALL =
		TOL_W'(2 * (longint'(2 ** COORD_W - 1) ** 2) + 1);
	localparam logic [TOL_W-1:0] TOL_ALL_ONES  = '1;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	// slot_index, coord_x, coord_y, start_index, zero pad
	logic [S_DATA_W-1:0] s_tdata;
	// command
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	// nearest_index, best_square_distance, zero pad
	logic [M_DATA_W-1:0] m_tdata;
	// within_tolerance
	logic                m_tuser;
	logic                cfg_valid;
	logic                cfg_ready;
	logic                cfg_index;
	logic [TOL_W-1:0]    cfg_data;

	int outstanding;
	int mismatches;

	// stimulus bookkeeping
	int  sent_items = 0;
	int  send_gap_pct = 0;
	int  recv_gap_pct = 0;
	bit  hold_req = 1'b0;
	int  quiet_cycles = 0;
	int  prefix = 0;
	bit  loaded_map [MAX_POINTS];
	int  loaded_list [$];

	nearest_point_window_search_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	npws_result_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if ($urandom_range(0, 99) < recv_gap_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 18)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// stop the run when no channel moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// offer one item, entered and left at a falling edge with valid still high
	task automatic send_item(input logic cmd, input logic [IDX_W-1:0] slot,
			input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [IDX_W-1:0] start);
		if ($urandom_range(0, 99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		s_tuser <= cmd;
		s_tdata <= S_DATA_W'({start, y, x, slot});
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		sent_items++;
	endtask

	// load a point and note which slots may now be searched
	task automatic load_point(input int slot, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y);
		if (!loaded_map[slot]) begin
			loaded_map[slot] = 1'b1;
			loaded_list.push_back(slot);
			while (prefix < MAX_POINTS && loaded_map[prefix]) begin
				prefix++;
			end
		end
		send_item(CMD_LOAD, IDX_W'(slot), x, y, IDX_W'($urandom));
	endtask

	task automatic write_reg(input logic idx, input logic [TOL_W-1:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// hold the input until every query has answered, then let the block settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (outstanding != 0 || hold_req) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [COORD_W-1:0] pick_coord(input int center, input int radius);
		int v;
		if (radius == FULL_SPREAD) begin
			return COORD_W'($urandom);
		end
		v = center + int'($urandom_range(0, 2 * radius)) - radius;
		if (v > COORD_MAX) begin
			v = COORD_MAX;
		end
		if (v < COORD_MIN) begin
			v = COORD_MIN;
		end
		return COORD_W'(v);
	endfunction

	initial begin : stimulus
		int               phase;
		int               count;
		int               eff_n;
		int               load_pct;
		int               len;
		int               radius;
		int               rad;
		int               cx;
		int               cy;
		int               cand;
		int               start;
		int               roll;
		int               slot;
		bit               wide;
		bit               tail;
		logic [TOL_W-1:0] tol;
		logic [TOL_W-1:0] cfg_word;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_LOAD;
		cfg_valid = 1'b0;
		cfg_index = CFG_POINT_COUNT;
		cfg_data = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed: extremes, clamping, ties, early stop, count saturation
		send_gap_pct = 20;
		recv_gap_pct = 20;
		load_point(0, C_LO, C_LO);
		send_item(CMD_QUERY, '0, C_HI, C_HI, IDX_W'(MAX_POINTS - 1));
		load_point(MAX_POINTS - 1, C_HI, C_HI);
		load_point(1, '0, '0);
		load_point(2, COORD_W'(3), COORD_W'(4));
		load_point(3, COORD_W'(-3), COORD_W'(-4));
		load_point(4, COORD_W'(5), '0);
		load_point(5, '0, COORD_W'(5));

		// count zero behaves as one point
		wait_idle();
		write_reg(CFG_POINT_COUNT, '0);
		send_item(CMD_QUERY, '0, COORD_W'(3), COORD_W'(4), IDX_W'(MAX_POINTS - 1));

		// full searches with equal distances
		wait_idle();
		write_reg(CFG_POINT_COUNT, TOL_W'(6));
		send_item(CMD_QUERY, '0, '0, '0, IDX_W'(3));
		send_item(CMD_QUERY, '0, COORD_W'(1), '0, IDX_W'(5));
		send_item(CMD_QUERY, '0, C_LO, C_LO, '0);
		send_item(CMD_QUERY, '0, COORD_W'(1), COORD_W'(1), IDX_W'(2));

		// early stop at the start point, and a search that never gets under
		wait_idle();
		write_reg(CFG_TOLERANCE, TOL_W'(26));
		send_item(CMD_QUERY, '0, '0, '0, IDX_W'(4));
		send_item(CMD_QUERY, '0, C_HI, C_HI, IDX_W'(2));

		// oversized counts saturate; every distance is under the tolerance
		wait_idle();
		write_reg(CFG_POINT_COUNT, TOL_W'(COUNT_ALL_ONES));
		write_reg(CFG_TOLERANCE, TOL_ALL_ONES);
		send_item(CMD_QUERY, '0, C_HI, C_HI, IDX_W'(MAX_POINTS - 1));
		send_item(CMD_QUERY, '0, C_LO, C_HI, '0);
		wait_idle();
		write_reg(CFG_POINT_COUNT, TOL_W'(MAX_POINTS + 1));
		write_reg(CFG_TOLERANCE, TOL_ABOVE_ALL);
		send_item(CMD_QUERY, '0, C_HI, C_LO, IDX_W'(MAX_POINTS - 1));

		// random phases, each with its own register setting
		phase = 0;
		while (sent_items < ITEMS) begin
			phase++;
			wait_idle();
			tail = (sent_items >= ITEMS - TAIL_ITEMS);
			case ($urandom_range(0, 3))
				0: send_gap_pct = 0;
				1: send_gap_pct = 10;
				default: send_gap_pct = 30;
			endcase
			case ($urandom_range(0, 3))
				0: recv_gap_pct = 0;
				1: recv_gap_pct = 10;
				default: recv_gap_pct = 30;
			endcase
			if (tail) begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end

			// wide phases stop at the start slot, so any count is safe
			wide = ($urandom_range(0, 99) < 15);
			if (wide) begin
				case ($urandom_range(0, 2))
					0: count = MAX_POINTS;
					1: count = COUNT_ALL_ONES;
					default: count = $urandom_range(1, COUNT_ALL_ONES);
				endcase
				tol = $urandom_range(0, 1) ? TOL_ABOVE_ALL : TOL_ALL_ONES;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 8) begin
					count = 0;
				end else if (roll < 60) begin
					count = $urandom_range(1, (prefix < 16) ? prefix : 16);
				end else if (roll < 85) begin
					count = $urandom_range(1, (prefix < 128) ? prefix : 128);
				end else begin
					count = $urandom_range(1, prefix);
				end
				roll = $urandom_range(0, 99);
				if (roll < 30) begin
					tol = '0;
				end else if (roll < 60) begin
					tol = TOL_W'($urandom_range(0, 4096));
				end else if (roll < 80) begin
					tol = TOL_W'($urandom_range(0, 1 << 24));
				end else begin
					tol = {1'($urandom_range(0, 1)), 32'($urandom)};
				end
			end
			if (count == 0) begin
				eff_n = 1;
			end else begin
				eff_n = (count > MAX_POINTS) ? MAX_POINTS : count;
			end

			// unused upper bits of the count write are sometimes noise
			cfg_word = TOL_W'(count);
			if ($urandom_range(0, 4) == 0) begin
				cfg_word[TOL_W-1:CNT_W] = (TOL_W - CNT_W)'($urandom);
			end
			if ($urandom_range(0, 1)) begin
				write_reg(CFG_POINT_COUNT, cfg_word);
				write_reg(CFG_TOLERANCE, tol);
			end else begin
				write_reg(CFG_TOLERANCE, tol);
				write_reg(CFG_POINT_COUNT, cfg_word);
			end

			case ($urandom_range(0, 3))
				0: radius = 3;
				1: radius = 64;
				2: radius = 2048;
				default: radius = FULL_SPREAD;
			endcase
			cx = int'($urandom_range(0, 2 ** COORD_W - 1)) + COORD_MIN;
			cy = int'($urandom_range(0, 2 ** COORD_W - 1)) + COORD_MIN;
			load_pct = (prefix < 64) ? 65 : $urandom_range(25, 60);
			len = $urandom_range(8, 48);

			// receiver holds off while queries keep coming
			if (!tail && phase % 11 == 4) begin
				hold_req = 1'b1;
				load_pct = 15;
			end

			for (int k = 0; k < len && sent_items < ITEMS; k++) begin
				if (!tail && $urandom_range(0, 199) == 0) begin
					wait_idle();
				end
				rad = ($urandom_range(0, 99) < 15) ? FULL_SPREAD : radius;
				if ($urandom_range(0, 99) < load_pct) begin
					roll = $urandom_range(0, 99);
					if (roll < 50 && prefix < MAX_POINTS) begin
						slot = prefix;
					end else if (roll < 70) begin
						slot = $urandom_range(0, eff_n - 1);
					end else begin
						slot = $urandom_range(0, MAX_POINTS - 1);
					end
					load_point(slot, pick_coord(cx, rad), pick_coord(cy, rad));
				end else begin
					if (wide) begin
						do begin
							cand = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
						end while (cand > eff_n - 1);
						start = (cand == eff_n - 1) ? $urandom_range(cand, MAX_POINTS - 1) : cand;
					end else if ($urandom_range(0, 3) == 0) begin
						start = $urandom_range(0, MAX_POINTS - 1);
					end else begin
						start = $urandom_range(0, eff_n - 1);
					end
					send_item(CMD_QUERY, IDX_W'($urandom), pick_coord(cx, rad),
						pick_coord(cy, rad), IDX_W'(start));
				end
			end
		end

		// drain and give the verdict
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/npws_pkg.sv
rtl/npws_ctrl.sv
rtl/npws_datapath.sv
rtl/nearest_point_window_search_core.sv
sim/npws_result_checker.sv
sim/tb_nearest_point_window_search_core.sv
